@@ design/nsc_pkg.sv @@
// Package for the normalized sample convolution unit.
// Holds the transaction payload types, command codes and widths shared by every module but nsc_ram.
// No dependencies.
package nsc_pkg;

    localparam logic [1:0] CMD_TAP    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_ZERO   = 2'd2;

    localparam int TAP_COUNT_W = 9;
    localparam int SAMPLE_W    = 16;
    localparam int PRODUCT_W   = 32;
    localparam int QUOT_W      = 17;
    localparam int NORM_W      = 15;
    localparam logic [NORM_W-1:0] NORM_DIV = 15'd32767;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [7:0]                 tap_index;
        logic signed [SAMPLE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result;
        logic                       saturated;
    } out_t;

endpackage

@@ design/nsc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module nsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nsc_mac.sv @@
// Multiply-accumulate engine: kernel and sample history memories and the tap sequencer.
// Depends on nsc_pkg and nsc_ram.
module nsc_mac
    import nsc_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   tap_we,
    input  logic [$clog2(MAX_TAPS)-1:0]            tap_addr,
    input  logic [SAMPLE_W-1:0]                    tap_data,
    input  logic                                   start,
    input  logic [SAMPLE_W-1:0]                    sample,
    input  logic [$clog2(MAX_TAPS+1)-1:0]          taps,
    output logic                                   acc_valid,
    output logic signed [PRODUCT_W+$clog2(MAX_TAPS+1)-1:0] acc
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TCW   = $clog2(MAX_TAPS+1);
    localparam int ACC_W = PRODUCT_W + TCW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                  st_reg;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               hist_addr_reg;
    logic [AW-1:0]               last_reg;
    logic [AW-1:0]               ptr_reg;
    logic [TCW-1:0]              fill_reg;
    logic                        p1_valid_reg;
    logic                        p1_live_reg;
    logic                        p2_valid_reg;
    logic signed [PRODUCT_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [SAMPLE_W-1:0]         kern_rdata;
    logic [SAMPLE_W-1:0]         hist_rdata;

    nsc_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_TAPS)
    ) u_kernel_ram (
        .aclk (aclk),
        .we   (tap_we),
        .waddr(tap_addr),
        .wdata(tap_data),
        .raddr(idx_reg),
        .rdata(kern_rdata)
    );

    nsc_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_TAPS)
    ) u_history_ram (
        .aclk (aclk),
        .we   (start && (st_reg == ST_IDLE)),
        .waddr(ptr_reg),
        .wdata(sample),
        .raddr(hist_addr_reg),
        .rdata(hist_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            idx_reg       <= '0;
            hist_addr_reg <= '0;
            last_reg      <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p1_live_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
        end else begin
            p1_valid_reg <= (st_reg == ST_RUN);
            p1_live_reg  <= (TCW'(idx_reg) < fill_reg);
            p2_valid_reg <= p1_valid_reg;
            if (p1_valid_reg && p1_live_reg) begin
                prod_reg <= $signed(kern_rdata) * $signed(hist_rdata);
            end else begin
                prod_reg <= '0;
            end
            if (p2_valid_reg) begin
                acc_reg <= acc_reg + {{(ACC_W-PRODUCT_W){prod_reg[PRODUCT_W-1]}}, prod_reg};
            end
            case (st_reg)
                ST_IDLE: begin
                    if (start) begin
                        st_reg        <= ST_RUN;
                        idx_reg       <= '0;
                        hist_addr_reg <= ptr_reg;
                        last_reg      <= AW'(taps - TCW'(1));
                        acc_reg       <= '0;
                        if (ptr_reg == AW'(MAX_TAPS-1)) begin
                            ptr_reg <= '0;
                        end else begin
                            ptr_reg <= ptr_reg + AW'(1);
                        end
                        if (fill_reg != TCW'(MAX_TAPS)) begin
                            fill_reg <= fill_reg + TCW'(1);
                        end
                    end
                end
                ST_RUN: begin
                    if (idx_reg == last_reg) begin
                        st_reg <= ST_DRAIN;
                    end
                    idx_reg <= idx_reg + AW'(1);
                    if (hist_addr_reg == '0) begin
                        hist_addr_reg <= AW'(MAX_TAPS-1);
                    end else begin
                        hist_addr_reg <= hist_addr_reg - AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        st_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    st_reg <= ST_IDLE;
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign acc_valid = (st_reg == ST_DONE);
    assign acc       = acc_reg;

endmodule

@@ design/nsc_div.sv @@
// Normalizing divider: divides the accumulated sum by 32767 times the tap count,
// truncating toward zero and saturating to 16 bits. Depends on nsc_pkg.
module nsc_div
    import nsc_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [PRODUCT_W+$clog2(MAX_TAPS+1)-1:0] acc,
    input  logic [$clog2(MAX_TAPS+1)-1:0]          taps,
    output logic                                   res_valid,
    output out_t                                   res,
    input  logic                                   res_ack
);

    localparam int TCW   = $clog2(MAX_TAPS+1);
    localparam int ACC_W = PRODUCT_W + TCW;
    localparam int DBW   = NORM_W + TCW;
    localparam int WW    = ACC_W + 1;
    localparam int CNT_W = $clog2(QUOT_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]        st_reg;
    logic [WW-1:0]     mag_reg;
    logic [WW-1:0]     dsh_reg;
    logic              neg_reg;
    logic              ovf_reg;
    logic [TCW-1:0]    taps_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    out_t              res_reg;
    logic [DBW-1:0]    divisor;
    logic [WW-1:0]     acc_ext;
    logic              fits;
    logic [QUOT_W-1:0] quot_neg;
    logic              sat;

    assign divisor  = DBW'(NORM_DIV) * DBW'(taps_reg);
    assign acc_ext  = {{(WW-ACC_W){acc[ACC_W-1]}}, acc};
    assign fits     = (mag_reg >= dsh_reg);
    assign quot_neg = QUOT_W'(0) - quot_reg;
    assign sat      = ovf_reg || (neg_reg ? (quot_reg > QUOT_W'(32768))
                                          : (quot_reg > QUOT_W'(32767)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            mag_reg  <= '0;
            dsh_reg  <= '0;
            neg_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            taps_reg <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            res_reg  <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (start) begin
                        st_reg   <= ST_MUL;
                        neg_reg  <= acc[ACC_W-1];
                        mag_reg  <= acc[ACC_W-1] ? (WW'(0) - acc_ext) : acc_ext;
                        taps_reg <= taps;
                    end
                end
                ST_MUL: begin
                    dsh_reg <= WW'(divisor) << QUOT_W;
                    st_reg  <= ST_CHK;
                end
                ST_CHK: begin
                    ovf_reg  <= fits;
                    dsh_reg  <= dsh_reg >> 1;
                    quot_reg <= '0;
                    cnt_reg  <= CNT_W'(QUOT_W-1);
                    st_reg   <= ST_STEP;
                end
                ST_STEP: begin
                    if (fits) begin
                        mag_reg <= mag_reg - dsh_reg;
                    end
                    quot_reg <= {quot_reg[QUOT_W-2:0], fits};
                    dsh_reg  <= dsh_reg >> 1;
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        st_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    res_reg.saturated <= sat;
                    if (sat) begin
                        res_reg.result <= neg_reg ? 16'sh8000 : 16'sh7fff;
                    end else if (neg_reg) begin
                        res_reg.result <= $signed(quot_neg[SAMPLE_W-1:0]);
                    end else begin
                        res_reg.result <= $signed(quot_reg[SAMPLE_W-1:0]);
                    end
                    st_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (res_ack) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = (st_reg == ST_HOLD);
    assign res       = res_reg;

endmodule

@@ design/normalized_sample_convolution_unit.sv @@
// Top level of the normalized sample convolution unit.
// Depends on nsc_pkg, nsc_mac and nsc_div.
//
// The s_ channel carries commands: a tap write loads one kernel tap, a sample push
// or a zero push shifts a value into the history and yields one output transaction
// on the m_ channel. Unused commands and writes beyond the kernel are dropped.
// The cfg_ channel writes the tap count; it is always ready and must only be used
// while no push is in flight.
// A push runs through the single multiply-accumulate unit fed by the kernel and
// history memories, one tap per cycle over the effective tap count, then through
// a 17-step restoring divider.
// One push is processed at a time; s_ready stays low until its result has moved
// into the output register.
// The output register holds the result until m_ready; the next command is taken
// while it waits, and a following push stalls in the divider if it is not taken.
// Reset clears the history pointer and fill count, so the history reads as zeros,
// and sets the tap count to one. Kernel taps are undefined until written.
module normalized_sample_convolution_unit
    import nsc_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TAP_COUNT_W-1:0] cfg_tap_count,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TCW   = $clog2(MAX_TAPS+1);
    localparam int ACC_W = PRODUCT_W + TCW;
    localparam int CW    = (TCW > TAP_COUNT_W) ? TCW : TAP_COUNT_W;

    logic [TAP_COUNT_W-1:0]  tap_count_reg;
    logic                    busy_reg;
    logic                    m_valid_reg;
    out_t                    m_data_reg;
    logic [CW-1:0]           tc_wide;
    logic [TCW-1:0]          eff_taps;
    logic                    s_accept;
    logic                    is_push;
    logic                    tap_we;
    logic                    acc_valid;
    logic signed [ACC_W-1:0] acc;
    logic                    res_valid;
    out_t                    res;
    logic                    res_ack;

    assign tc_wide = CW'(tap_count_reg);

    always_comb begin
        if (tap_count_reg == '0) begin
            eff_taps = TCW'(1);
        end else if (tc_wide > CW'(MAX_TAPS)) begin
            eff_taps = TCW'(MAX_TAPS);
        end else begin
            eff_taps = TCW'(tc_wide);
        end
    end

    assign s_ready  = !busy_reg;
    assign s_accept = s_valid && s_ready;
    assign is_push  = (s_data.cmd == CMD_SAMPLE) || (s_data.cmd == CMD_ZERO);
    assign tap_we   = s_accept && (s_data.cmd == CMD_TAP) && (32'(s_data.tap_index) < MAX_TAPS);
    assign res_ack  = res_valid && (!m_valid_reg || m_ready);

    nsc_mac #(
        .MAX_TAPS(MAX_TAPS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tap_we   (tap_we),
        .tap_addr (AW'(s_data.tap_index)),
        .tap_data (s_data.value),
        .start    (s_accept && is_push),
        .sample   ((s_data.cmd == CMD_SAMPLE) ? s_data.value : '0),
        .taps     (eff_taps),
        .acc_valid(acc_valid),
        .acc      (acc)
    );

    nsc_div #(
        .MAX_TAPS(MAX_TAPS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (acc_valid),
        .acc      (acc),
        .taps     (eff_taps),
        .res_valid(res_valid),
        .res      (res),
        .res_ack  (res_ack)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_W'(1);
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                tap_count_reg <= cfg_tap_count;
            end
            if (s_accept && is_push) begin
                busy_reg <= 1'b1;
            end else if (res_ack) begin
                busy_reg <= 1'b0;
            end
            if (res_ack) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

@@ bench/nsc_output_checker.sv @@
// Output checker for the normalized sample convolution unit.
// Watches the cfg_, s_ and m_ channels, predicts every output transaction and compares it.
// Depends on nsc_pkg.
module nsc_output_checker
    import nsc_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [TAP_COUNT_W-1:0] cfg_tap_count,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_t                    s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_t                   m_data,
    output int                     errors,
    output int                     pending,
    output int                     outputs_seen,
    output int                     saturated_seen
);

    logic signed [SAMPLE_W-1:0] kernel [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    int                         hist_ptr;
    logic [TAP_COUNT_W-1:0]     tap_count;
    out_t                       expected_outputs [$];
    int                         err_cnt;
    int                         out_cnt;
    int                         sat_cnt;

    initial begin
        errors = 0;
        pending = 0;
        outputs_seen = 0;
        saturated_seen = 0;
        err_cnt = 0;
        out_cnt = 0;
        sat_cnt = 0;
        hist_ptr = 0;
        tap_count = 1;
        for (int i = 0; i < MAX_TAPS; i++) begin
            kernel[i] = '0;
            history[i] = '0;
        end
    end

    function automatic out_t filter_push(logic signed [SAMPLE_W-1:0] sample);
        int     taps;
        int     slot;
        longint acc;
        longint quo;
        out_t   y;
        taps = (tap_count == 0) ? 1 : ((tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
        history[hist_ptr] = sample;
        acc = 0;
        for (int i = 0; i < taps; i++) begin
            slot = (hist_ptr + MAX_TAPS - i) % MAX_TAPS;
            acc += longint'(kernel[i]) * longint'(history[slot]);
        end
        hist_ptr = (hist_ptr + 1) % MAX_TAPS;
        quo = acc / (longint'(32767) * longint'(taps));
        y.saturated = 1'b0;
        if (quo > 32767) begin
            y.result = 16'sh7fff;
            y.saturated = 1'b1;
        end else if (quo < -32768) begin
            y.result = 16'sh8000;
            y.saturated = 1'b1;
        end else begin
            y.result = quo[SAMPLE_W-1:0];
        end
        return y;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            hist_ptr = 0;
            tap_count = 1;
            for (int i = 0; i < MAX_TAPS; i++) begin
                history[i] = '0;
            end
            expected_outputs.delete();
        end else begin
            if (m_valid && m_ready) begin
                out_cnt++;
                if (m_data.saturated === 1'b1) begin
                    sat_cnt++;
                end
                if (expected_outputs.size() == 0) begin
                    $error("unexpected output transaction: result %0d, saturated %0b",
                           m_data.result, m_data.saturated);
                    err_cnt++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_data.result !== want.result) begin
                        $error("result mismatch: expected %0d, actual %0d",
                               want.result, m_data.result);
                        err_cnt++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, m_data.saturated);
                        err_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                tap_count = cfg_tap_count;
            end
            if (s_valid && s_ready) begin
                case (s_data.cmd)
                    CMD_TAP: begin
                        if (s_data.tap_index < MAX_TAPS) begin
                            kernel[s_data.tap_index] = s_data.value;
                        end
                    end
                    CMD_SAMPLE: begin
                        expected_outputs.push_back(filter_push(s_data.value));
                    end
                    CMD_ZERO: begin
                        expected_outputs.push_back(filter_push('0));
                    end
                    default: begin
                    end
                endcase
            end
        end
        errors <= err_cnt;
        pending <= expected_outputs.size();
        outputs_seen <= out_cnt;
        saturated_seen <= sat_cnt;
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the normalized sample convolution unit.
// Generates tap writes, sample and zero pushes and tap-count writes with random idling,
// and gives the verdict. Depends on nsc_pkg, the unit and nsc_output_checker.
module tb;
    import nsc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         MAX_TAPS   = 256;
    localparam int         SETTLE     = 300;
    localparam int         LIMIT      = 3_000_000;
    localparam int         LONG_HOLD  = 2500;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TAP_COUNT_W-1:0] cfg_tap_count = 9'd1;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_t                    s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_t                   m_data;

    int errors;
    int pending;
    int outputs_seen;
    int saturated_seen;
    int cycles = 0;
    int commands_sent = 0;
    int settings_written = 0;
    bit tap_written [MAX_TAPS];
    bit burst_mode = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    normalized_sample_convolution_unit #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_tap_count(cfg_tap_count),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    nsc_output_checker #(
        .MAX_TAPS(MAX_TAPS)
    ) check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_tap_count (cfg_tap_count),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .errors        (errors),
        .pending       (pending),
        .outputs_seen  (outputs_seen),
        .saturated_seen(saturated_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timed out after %0d cycles with %0d outputs outstanding.", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_value();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 10) begin
            return 16'h7fff;
        end else if (r < 20) begin
            return 16'h8000;
        end else if (r < 25) begin
            return 16'h0000;
        end else if (r < 28) begin
            return 16'h0001;
        end else if (r < 31) begin
            return 16'hffff;
        end
        return w[SAMPLE_W-1:0];
    endfunction

    initial begin
        int stall;
        int run;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                stall = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            run = $urandom_range(1, 10);
            repeat (run - 1) @(negedge aclk);
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic [7:0] idx, logic [SAMPLE_W-1:0] val);
        int  gap;
        in_t item;
        gap = pick_gap();
        item.cmd = cmd;
        item.tap_index = idx;
        item.value = val;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_TAP) begin
            tap_written[idx] = 1'b1;
        end
        if (cmd != CMD_UNUSED) begin
            commands_sent++;
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_tap_count(logic [TAP_COUNT_W-1:0] count);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_tap_count <= count;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    initial begin
        int settings [12];
        int taps;
        int quota;
        int start;
        int r;
        int len;
        int tail;
        logic [31:0] w;

        settings = '{3, 1, 8, 511, 5, 64, 2, 256, 16, 0, 7, 2};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        send_cmd(CMD_TAP, 8'd0, 16'h7fff);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h7fff);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h8000);
        send_cmd(CMD_TAP, 8'd0, 16'h8000);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h8000);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h7fff);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h0001);
        send_cmd(CMD_SAMPLE, 8'd0, 16'hffff);
        send_cmd(CMD_ZERO, 8'hff, 16'hffff);
        send_cmd(CMD_UNUSED, 8'hff, 16'hffff);
        send_cmd(CMD_TAP, 8'd255, 16'h7fff);
        send_cmd(CMD_TAP, 8'd128, 16'h8000);
        send_cmd(CMD_TAP, 8'd1, 16'h8000);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h0000);
        set_tap_count(9'd0);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h8000);
        set_tap_count(9'd2);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h8000);
        send_cmd(CMD_SAMPLE, 8'd0, 16'h7fff);
        send_cmd(CMD_ZERO, 8'd0, 16'h0000);
        send_cmd(CMD_ZERO, 8'd0, 16'h0000);

        for (int p = 0; p < 12; p++) begin
            set_tap_count(settings[p][TAP_COUNT_W-1:0]);
            taps = (settings[p] == 0) ? 1 : ((settings[p] > MAX_TAPS) ? MAX_TAPS : settings[p]);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < taps; i++) begin
                if (!tap_written[i]) begin
                    send_cmd(CMD_TAP, i[7:0], rand_value());
                end
            end
            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            quota = (taps >= 64) ? 12 : 40;
            start = commands_sent;
            while (commands_sent - start < quota) begin
                r = $urandom_range(0, 99);
                w = $urandom;
                if (r < 65) begin
                    len = $urandom_range(1, 12);
                    tail = (taps <= 16) ? taps - 1 : $urandom_range(0, 12);
                    repeat (len) begin
                        w = $urandom;
                        send_cmd(CMD_SAMPLE, w[7:0], rand_value());
                    end
                    repeat (tail) begin
                        w = $urandom;
                        send_cmd(CMD_ZERO, w[7:0], w[23:8]);
                    end
                end else if (r < 80) begin
                    send_cmd(CMD_TAP, w[7:0], rand_value());
                end else if (r < 90) begin
                    send_cmd(CMD_UNUSED, w[7:0], w[23:8]);
                end else begin
                    send_cmd(CMD_ZERO, w[7:0], w[23:8]);
                end
            end
        end

        wait_idle();
        $display("Sent %0d commands over %0d tap-count writes, from 0 and 1 up to 256 and 511.",
                 commands_sent, settings_written);
        $display("Checked %0d output transactions, %0d of them saturated.",
                 outputs_seen, saturated_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
